@@ design/grdi_pkg.sv @@
// Shared types, constants and helpers for the genotype row decode and impute block.
package grdi_pkg;

  // Storage and arithmetic sizing.
  localparam int MAX_KEPT       = 4096;
  localparam int FRAC_BITS      = 14;
  localparam int CODES_PER_BYTE = 4;
  localparam int ADDR_W         = $clog2(MAX_KEPT);
  localparam int PTR_W          = ADDR_W + 1;
  localparam int SUM_W          = PTR_W + 1;
  localparam int DIV_W          = SUM_W + FRAC_BITS;
  localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
  localparam int BANK_SEL_W     = $clog2(CODES_PER_BYTE);
  localparam int BANK_DEPTH     = MAX_KEPT / CODES_PER_BYTE;
  localparam int BANK_AW        = $clog2(BANK_DEPTH);
  localparam int TAKEN_W        = $clog2(CODES_PER_BYTE + 1);
  localparam int COUNT_W        = 16;
  localparam int DOSAGE_W       = FRAC_BITS + 2;
  localparam int READ_IDX_W     = 12;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration port.
  localparam int APB_AW    = 3;
  localparam int APB_DW    = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_INDIVIDUAL_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0]   COUNT_RESET          = 16'd1;

  // Input operation and result kind codes.
  localparam logic OP_LOAD        = 1'b0;
  localparam logic OP_READ        = 1'b1;
  localparam logic RESULT_SUMMARY = 1'b0;
  localparam logic RESULT_READ    = 1'b1;

  typedef enum logic [1:0] {
    GENO_HOM_FIRST  = 2'b00,
    GENO_MISSING    = 2'b01,
    GENO_HET        = 2'b10,
    GENO_HOM_SECOND = 2'b11
  } geno_code_t;

  typedef struct packed {
    logic                  op;
    logic [7:0]            packed_byte;
    logic [3:0]            keep_mask;
    logic                  row_selected;
    logic                  last_byte;
    logic [READ_IDX_W-1:0] read_index;
  } item_t;

  typedef struct packed {
    logic                result_kind;
    logic [DOSAGE_W-1:0] dosage_fixed;
    logic                was_missing;
    logic [PTR_W-1:0]    kept_total;
    logic [PTR_W-1:0]    missing_total;
    logic                none_observed;
  } result_t;

  typedef enum logic {
    ENTRY_LOAD,
    ENTRY_READ
  } entry_kind_t;

  typedef struct packed {
    entry_kind_t           kind;
    logic [7:0]            packed_byte;
    logic [3:0]            keep_mask;
    logic                  last_byte;
    logic [READ_IDX_W-1:0] read_index;
  } queue_entry_t;

  typedef enum logic [1:0] {
    BK_RUN,
    BK_READ,
    BK_DIVIDE
  } back_state_t;

  // Allele dosage of an observed code; a missing code counts as zero here.
  function automatic logic [1:0] dosage_of(input logic [1:0] code);
    logic [1:0] d;
    unique case (code)
      GENO_HOM_FIRST:  d = 2'd2;
      GENO_HET:        d = 2'd1;
      GENO_HOM_SECOND: d = 2'd0;
      default:         d = 2'd0;
    endcase
    return d;
  endfunction

endpackage

@@ design/genotype_row_decode_impute.sv @@
// Top level of the genotype row decoder with mean imputation.
//
//   Channel   Signals                                  Beat taken when
//   command   start, busy, item                        start && !busy
//   result    result_valid, result                     result_valid (one cycle)
//   config    psel penable pwrite paddr pwdata prdata  psel && penable && pwrite
//
// The back end stores a load byte as it leaves the queue; the four code banks
// store a whole byte at once. A dosage read holds the back end for the registered
// bank read. A row's last byte holds the back end while the bit-serial mean divider
// runs, unless nothing was observed. A two-beat queue lets commands arrive while the
// back end works; busy rises only when it is full. Reset is synchronous and clears
// all control state; the code store holds no reset value. No result stalls.
module genotype_row_decode_impute (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grdi_pkg::APB_AW-1:0]   paddr,
  input  logic [grdi_pkg::APB_DW-1:0]   pwdata,
  output logic [grdi_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  input  logic                          start,
  input  grdi_pkg::item_t               item,
  output logic                          busy,
  output logic                          result_valid,
  output grdi_pkg::result_t             result
);

  logic [grdi_pkg::COUNT_W-1:0]   individual_count;
  logic                           reg_hit;
  logic                           q_valid;
  logic                           pop;
  grdi_pkg::queue_entry_t         q_entry;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[grdi_pkg::APB_AW-1:2] == grdi_pkg::REG_INDIVIDUAL_COUNT);
  assign prdata  = reg_hit ? grdi_pkg::APB_DW'(individual_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      individual_count <= grdi_pkg::COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      individual_count <= pwdata[grdi_pkg::COUNT_W-1:0];
    end
  end

  grdi_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .pop     (pop),
    .q_valid (q_valid),
    .q_entry (q_entry)
  );

  grdi_back u_back (
    .clk              (clk),
    .rst              (rst),
    .individual_count (individual_count),
    .q_valid          (q_valid),
    .q_entry          (q_entry),
    .pop              (pop),
    .result_valid     (result_valid),
    .result           (result)
  );

endmodule

@@ design/grdi_divider.sv @@
// Restoring divider that forms the rounded row mean, one quotient bit per cycle.
module grdi_divider (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [grdi_pkg::DIV_W-1:0]  dividend,
  input  logic [grdi_pkg::PTR_W-1:0]  divisor,
  output logic                        done,
  output logic [grdi_pkg::DIV_W-1:0]  quotient
);

  logic                            active;
  logic [grdi_pkg::DIV_CNT_W-1:0]  cnt;
  logic [grdi_pkg::PTR_W-1:0]      rem;
  logic [grdi_pkg::DIV_W-1:0]      quo;
  logic [grdi_pkg::PTR_W-1:0]      dvs;
  logic [grdi_pkg::PTR_W:0]        trial;
  logic                            fits;

  assign trial    = {rem, quo[grdi_pkg::DIV_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign done     = active && (cnt == '0);
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      cnt    <= grdi_pkg::DIV_CNT_W'(grdi_pkg::DIV_W);
    end else if (active) begin
      if (cnt == '0) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // The divisor is held here, since the source moves on once the divide starts.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (active && (cnt != '0)) begin
      // The remainder stays below the divisor, so the difference fits.
      rem <= fits ? grdi_pkg::PTR_W'(trial - {1'b0, dvs})
                  : trial[grdi_pkg::PTR_W-1:0];
      quo <= {quo[grdi_pkg::DIV_W-2:0], fits};
    end
  end

endmodule

@@ design/grdi_front.sv @@
// Front end: takes commands, drops loads of skipped rows, queues the rest.
module grdi_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  grdi_pkg::item_t        item,
  output logic                   busy,
  input  logic                   pop,
  output logic                   q_valid,
  output grdi_pkg::queue_entry_t q_entry
);

  grdi_pkg::queue_entry_t          entries [grdi_pkg::QUEUE_DEPTH];
  logic [grdi_pkg::QPTR_W-1:0]     wr_ptr;
  logic [grdi_pkg::QPTR_W-1:0]     rd_ptr;
  logic [grdi_pkg::QCNT_W-1:0]     count;
  logic                            push;
  grdi_pkg::queue_entry_t          push_entry;

  assign busy    = (count == grdi_pkg::QCNT_W'(grdi_pkg::QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_entry = entries[rd_ptr];

  // A load of an unselected row has no effect, so it never enters the queue.
  assign push = start && !busy && ((item.op == grdi_pkg::OP_READ) || item.row_selected);

  always_comb begin
    push_entry.kind        = (item.op == grdi_pkg::OP_READ) ? grdi_pkg::ENTRY_READ
                                                            : grdi_pkg::ENTRY_LOAD;
    push_entry.packed_byte = item.packed_byte;
    push_entry.keep_mask   = item.keep_mask;
    push_entry.last_byte   = item.last_byte;
    push_entry.read_index  = item.read_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + grdi_pkg::QCNT_W'(push) - grdi_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ design/grdi_back.sv @@
// Back end: decodes and stores kept codes, forms the row mean, serves dosage reads.
module grdi_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [grdi_pkg::COUNT_W-1:0]  individual_count,
  input  logic                          q_valid,
  input  grdi_pkg::queue_entry_t        q_entry,
  output logic                          pop,
  output logic                          result_valid,
  output grdi_pkg::result_t             result
);

  grdi_pkg::back_state_t state;
  grdi_pkg::back_state_t state_next;

  logic [grdi_pkg::PTR_W-1:0]    wp;
  logic [grdi_pkg::COUNT_W-1:0]  pos;
  logic [grdi_pkg::SUM_W-1:0]    dsum;
  logic [grdi_pkg::PTR_W-1:0]    obs;
  logic [grdi_pkg::DOSAGE_W-1:0] row_mean;

  // One bank per code position of a byte, so a whole byte stores at once.
  logic [1:0] bank_mem [grdi_pkg::CODES_PER_BYTE][grdi_pkg::BANK_DEPTH];
  logic [1:0] rd_code  [grdi_pkg::CODES_PER_BYTE];
  logic [grdi_pkg::BANK_SEL_W-1:0] rd_bank;
  logic                            rd_hit;

  logic [grdi_pkg::CODES_PER_BYTE-1:0] bank_we;
  logic [grdi_pkg::BANK_AW-1:0]        bank_row  [grdi_pkg::CODES_PER_BYTE];
  logic [1:0]                          bank_code [grdi_pkg::CODES_PER_BYTE];

  logic [grdi_pkg::PTR_W-1:0]    wp_new;
  logic [grdi_pkg::SUM_W-1:0]    sum_new;
  logic [grdi_pkg::PTR_W-1:0]    obs_new;
  logic [grdi_pkg::TAKEN_W-1:0]  taken;
  logic [grdi_pkg::COUNT_W-1:0]  pos_new;

  logic                         is_load;
  logic                         is_read;
  logic                         load_en;
  logic                         read_en;
  logic                         div_start;
  logic                         emit_empty;
  logic                         emit_read;
  logic                         emit_mean;
  logic                         div_done;
  logic [grdi_pkg::DIV_W-1:0]   dividend;
  logic [grdi_pkg::DIV_W-1:0]   quotient;
  logic [1:0]                   sel_code;
  grdi_pkg::result_t            result_next;

  assign is_load = (q_entry.kind == grdi_pkg::ENTRY_LOAD);
  assign is_read = (q_entry.kind == grdi_pkg::ENTRY_READ);

  // Byte decode: codes past the individual count are padding, and kept codes
  // beyond the store's depth are dropped without being counted.
  always_comb begin
    logic [1:0]                 code_n;
    logic [grdi_pkg::PTR_W-1:0] slot;
    slot    = (pos == '0) ? '0 : wp;
    sum_new = (pos == '0) ? '0 : dsum;
    obs_new = (pos == '0) ? '0 : obs;
    taken   = '0;
    bank_we = '0;
    code_n  = '0;
    for (int b = 0; b < grdi_pkg::CODES_PER_BYTE; b++) begin
      bank_row[b]  = '0;
      bank_code[b] = '0;
    end
    for (int n = 0; n < grdi_pkg::CODES_PER_BYTE; n++) begin
      code_n = q_entry.packed_byte[2*n +: 2];
      if (({1'b0, pos} + (grdi_pkg::COUNT_W + 1)'(n)) < {1'b0, individual_count}) begin
        taken = taken + 1'b1;
        if (q_entry.keep_mask[n] && (slot < grdi_pkg::PTR_W'(grdi_pkg::MAX_KEPT))) begin
          bank_we[slot[grdi_pkg::BANK_SEL_W-1:0]]   = 1'b1;
          bank_row[slot[grdi_pkg::BANK_SEL_W-1:0]]  =
            slot[grdi_pkg::ADDR_W-1:grdi_pkg::BANK_SEL_W];
          bank_code[slot[grdi_pkg::BANK_SEL_W-1:0]] = code_n;
          slot = slot + 1'b1;
          if (code_n != grdi_pkg::GENO_MISSING) begin
            sum_new = sum_new + grdi_pkg::SUM_W'(grdi_pkg::dosage_of(code_n));
            obs_new = obs_new + 1'b1;
          end
        end
      end
    end
    wp_new  = slot;
    pos_new = pos + grdi_pkg::COUNT_W'(taken);
  end

  // Rounded mean numerator: sum scaled to the fixed point plus half the count.
  assign dividend = {sum_new, {grdi_pkg::FRAC_BITS{1'b0}}}
                  + grdi_pkg::DIV_W'(obs_new[grdi_pkg::PTR_W-1:1]);

  grdi_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (obs_new),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    unique case (state)
      grdi_pkg::BK_RUN: begin
        if (q_valid && is_read) begin
          state_next = grdi_pkg::BK_READ;
        end else if (q_valid && is_load && q_entry.last_byte && (obs_new != '0)) begin
          state_next = grdi_pkg::BK_DIVIDE;
        end else begin
          state_next = grdi_pkg::BK_RUN;
        end
      end
      grdi_pkg::BK_READ:   state_next = grdi_pkg::BK_RUN;
      grdi_pkg::BK_DIVIDE: state_next = div_done ? grdi_pkg::BK_RUN : grdi_pkg::BK_DIVIDE;
      default:             state_next = grdi_pkg::BK_RUN;
    endcase
  end

  always_comb begin
    pop        = (state == grdi_pkg::BK_RUN) && q_valid;
    load_en    = pop && is_load;
    read_en    = pop && is_read;
    div_start  = load_en && q_entry.last_byte && (obs_new != '0);
    emit_empty = load_en && q_entry.last_byte && (obs_new == '0);
    emit_read  = (state == grdi_pkg::BK_READ);
    emit_mean  = (state == grdi_pkg::BK_DIVIDE) && div_done;
  end

  assign sel_code = rd_code[rd_bank];

  always_comb begin
    result_next = '0;
    if (emit_read) begin
      result_next.result_kind   = grdi_pkg::RESULT_READ;
      result_next.kept_total    = wp;
      result_next.missing_total = wp - obs;
      result_next.none_observed = (obs == '0);
      if (rd_hit && (sel_code == grdi_pkg::GENO_MISSING)) begin
        result_next.dosage_fixed = row_mean;
        result_next.was_missing  = 1'b1;
      end else if (rd_hit) begin
        result_next.dosage_fixed = {grdi_pkg::dosage_of(sel_code),
                                    {grdi_pkg::FRAC_BITS{1'b0}}};
      end
    end else if (emit_mean) begin
      result_next.result_kind   = grdi_pkg::RESULT_SUMMARY;
      result_next.dosage_fixed  = quotient[grdi_pkg::DOSAGE_W-1:0];
      result_next.kept_total    = wp;
      result_next.missing_total = wp - obs;
      result_next.none_observed = (obs == '0);
    end else begin
      // Row end with nothing observed: the mean is zero and needs no divide.
      result_next.result_kind   = grdi_pkg::RESULT_SUMMARY;
      result_next.kept_total    = wp_new;
      result_next.missing_total = wp_new - obs_new;
      result_next.none_observed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= grdi_pkg::BK_RUN;
      wp           <= '0;
      pos          <= '0;
      dsum         <= '0;
      obs          <= '0;
      row_mean     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit_read || emit_mean || emit_empty;
      if (load_en) begin
        wp   <= wp_new;
        dsum <= sum_new;
        obs  <= obs_new;
        pos  <= q_entry.last_byte ? '0 : pos_new;
      end
      if (emit_empty) begin
        row_mean <= '0;
      end else if (emit_mean) begin
        row_mean <= quotient[grdi_pkg::DOSAGE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_read || emit_mean || emit_empty) begin
      result <= result_next;
    end
    if (read_en) begin
      rd_bank <= q_entry.read_index[grdi_pkg::BANK_SEL_W-1:0];
      rd_hit  <= grdi_pkg::PTR_W'(q_entry.read_index) < wp;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < grdi_pkg::CODES_PER_BYTE; b++) begin
      if (load_en && bank_we[b]) begin
        bank_mem[b][bank_row[b]] <= bank_code[b];
      end
      if (read_en) begin
        rd_code[b] <=
          bank_mem[b][q_entry.read_index[grdi_pkg::ADDR_W-1:grdi_pkg::BANK_SEL_W]];
      end
    end
  end

endmodule

@@ design/grdi_checker.sv @@
// Port-level checks on the genotype row decoder, bound to its top level.
module grdi_checker (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              result_valid,
  input grdi_pkg::result_t result
);

  // Reset empties the queue and drops any pending result.
  a_reset_quiet: assert property (@(posedge clk) rst |=> (!busy && !result_valid))
    else $error("busy or result strobe after reset");

  a_missing_le_kept: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.missing_total <= result.kept_total))
    else $error("missing count exceeds kept count");

  a_summary_not_imputed: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.result_kind == grdi_pkg::RESULT_SUMMARY))
      |-> !result.was_missing)
    else $error("row summary flagged as imputed");

  // A row that ends with nothing observed has a zero mean.
  a_empty_mean_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.none_observed &&
     (result.result_kind == grdi_pkg::RESULT_SUMMARY))
      |-> (result.dosage_fixed == '0))
    else $error("nonzero mean for a row with no observation");

  a_dosage_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.dosage_fixed <= {2'd2, {grdi_pkg::FRAC_BITS{1'b0}}}))
    else $error("dosage above two");

endmodule

bind genotype_row_decode_impute grdi_checker u_grdi_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);
